[hdl/slbc_pkg.sv]
// Shared types and constants for the section layout bounds checker.
package slbc_pkg;

  localparam int unsigned ADDR_W = 32;
  localparam int unsigned NUM_CLASSES = 4;
  localparam logic [ADDR_W-1:0] ALL_ONES = 32'hFFFF_FFFF;

  // Section classes, in default chain order.
  typedef enum logic [1:0] {
    CLS_DATA = 2'd0,
    CLS_READ = 2'd1,
    CLS_TEXT = 2'd2,
    CLS_TEMP = 2'd3
  } class_t;

  // Section flag bit positions.
  localparam int unsigned FLAG_WRITE_BIT = 0;
  localparam int unsigned FLAG_ALLOC_BIT = 1;
  localparam int unsigned FLAG_EXEC_BIT  = 2;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_TABLE_OFFSET     = 3'd0,
    REG_TABLE_COUNT      = 3'd1,
    REG_TABLE_ENTRY_SIZE = 3'd2,
    REG_TYPE_FILE_INFO   = 3'd3,
    REG_TYPE_IMPORTS     = 3'd4,
    REG_TYPE_CHECKSUMS   = 3'd5,
    REG_TYPE_NO_BITS     = 3'd6,
    REG_TYPE_EXPORTS     = 3'd7
  } reg_index_t;

  // Fail codes, in check order.
  typedef enum logic [3:0] {
    FAIL_NONE           = 4'd0,
    FAIL_DATA_BEFORE_TBL = 4'd1,
    FAIL_DATA_LO_HI     = 4'd2,
    FAIL_DATA_LO_READ   = 4'd3,
    FAIL_DATA_HI_READ   = 4'd4,
    FAIL_READ_LO_HI     = 4'd5,
    FAIL_READ_LO_TEXT   = 4'd6,
    FAIL_READ_HI_TEXT   = 4'd7,
    FAIL_TEXT_LO_HI     = 4'd8,
    FAIL_TEXT_LO_TEMP   = 4'd9,
    FAIL_TEXT_HI_TEMP   = 4'd10,
    FAIL_TEMP_LO_HI     = 4'd11
  } fail_t;

  // Final span snapshot of all classes, taken on the last section.
  typedef struct packed {
    logic [NUM_CLASSES-1:0]             used;
    logic [NUM_CLASSES-1:0][ADDR_W-1:0] lo;
    logic [NUM_CLASSES-1:0][ADDR_W-1:0] hi;
  } span_t;

endpackage

[hdl/slbc_check.sv]
// Default fill of empty classes and the ordered layout checks.
module slbc_check (
  input  slbc_pkg::span_t              span,
  input  logic [slbc_pkg::ADDR_W-1:0]  tbl_offset,
  input  logic [slbc_pkg::ADDR_W-1:0]  tbl_end,
  output slbc_pkg::fail_t              code
);

  logic [slbc_pkg::NUM_CLASSES-1:0][slbc_pkg::ADDR_W-1:0] lo;
  logic [slbc_pkg::NUM_CLASSES-1:0][slbc_pkg::ADDR_W-1:0] hi;

  // Empty classes collapse onto the end of the previous class.
  always_comb begin
    logic [slbc_pkg::ADDR_W-1:0] prev;
    prev = tbl_end;
    for (int k = 0; k < slbc_pkg::NUM_CLASSES; k++) begin
      lo[k] = span.used[k] ? span.lo[k] : prev;
      hi[k] = span.used[k] ? span.hi[k] : prev;
      prev  = hi[k];
    end
  end

  always_comb begin
    if (lo[slbc_pkg::CLS_DATA] < tbl_offset) begin
      code = slbc_pkg::FAIL_DATA_BEFORE_TBL;
    end else if (lo[slbc_pkg::CLS_DATA] > hi[slbc_pkg::CLS_DATA]) begin
      code = slbc_pkg::FAIL_DATA_LO_HI;
    end else if (lo[slbc_pkg::CLS_DATA] > lo[slbc_pkg::CLS_READ]) begin
      code = slbc_pkg::FAIL_DATA_LO_READ;
    end else if (hi[slbc_pkg::CLS_DATA] > lo[slbc_pkg::CLS_READ]) begin
      code = slbc_pkg::FAIL_DATA_HI_READ;
    end else if (lo[slbc_pkg::CLS_READ] > hi[slbc_pkg::CLS_READ]) begin
      code = slbc_pkg::FAIL_READ_LO_HI;
    end else if (lo[slbc_pkg::CLS_READ] > lo[slbc_pkg::CLS_TEXT]) begin
      code = slbc_pkg::FAIL_READ_LO_TEXT;
    end else if (hi[slbc_pkg::CLS_READ] > lo[slbc_pkg::CLS_TEXT]) begin
      code = slbc_pkg::FAIL_READ_HI_TEXT;
    end else if (lo[slbc_pkg::CLS_TEXT] > hi[slbc_pkg::CLS_TEXT]) begin
      code = slbc_pkg::FAIL_TEXT_LO_HI;
    end else if (lo[slbc_pkg::CLS_TEXT] > lo[slbc_pkg::CLS_TEMP]) begin
      code = slbc_pkg::FAIL_TEXT_LO_TEMP;
    end else if (hi[slbc_pkg::CLS_TEXT] > lo[slbc_pkg::CLS_TEMP]) begin
      code = slbc_pkg::FAIL_TEXT_HI_TEMP;
    end else if (lo[slbc_pkg::CLS_TEMP] > hi[slbc_pkg::CLS_TEMP]) begin
      code = slbc_pkg::FAIL_TEMP_LO_HI;
    end else begin
      code = slbc_pkg::FAIL_NONE;
    end
  end

endmodule

[hdl/section_layout_bounds_check.sv]
// Top level: section classifier, per-class span tracking and layout check.
// Result path: a word marked tlast gives its result on m_tdata through the input
//   register, then the check register, then the result register.
// Throughput: one section header per cycle; only a last word waits, and only
//   while the check register is held by a stalled result.
// Reset (rst, synchronous): configuration registers take their default values, valid flags and spans clear.
module section_layout_bounds_check (
  input  logic         clk,
  input  logic         rst,
  // configuration
  input  logic         cfg_wr_en,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  // section headers in
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,   // sec_size, sec_type, sec_flags, sec_offset
  input  logic         s_tlast,   // last_section
  // check result out
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [7:0]   m_tdata    // layout_ok, fail_code[3:0], zero fill
);

  localparam int unsigned AW = slbc_pkg::ADDR_W;
  localparam int unsigned NC = slbc_pkg::NUM_CLASSES;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [AW-1:0] table_offset;
  logic [15:0]   table_count;
  logic [15:0]   table_entry_size;
  logic [AW-1:0] type_file_info;
  logic [AW-1:0] type_imports;
  logic [AW-1:0] type_checksums;
  logic [AW-1:0] type_no_bits;
  logic [AW-1:0] type_exports;
  logic [AW-1:0] tbl_end;   // end of the header table, default start of data

  always_ff @(posedge clk) begin
    if (rst) begin
      table_offset     <= '0;
      table_count      <= '0;
      table_entry_size <= 16'd40;
      type_file_info   <= 32'h8000_0004;
      type_imports     <= 32'h8000_0002;
      type_checksums   <= 32'h8000_0003;
      type_no_bits     <= 32'd8;
      type_exports     <= 32'h8000_0001;
    end else if (cfg_wr_en) begin
      case (slbc_pkg::reg_index_t'(cfg_index))
        slbc_pkg::REG_TABLE_OFFSET:     table_offset     <= cfg_data;
        slbc_pkg::REG_TABLE_COUNT:      table_count      <= cfg_data[15:0];
        slbc_pkg::REG_TABLE_ENTRY_SIZE: table_entry_size <= cfg_data[15:0];
        slbc_pkg::REG_TYPE_FILE_INFO:   type_file_info   <= cfg_data;
        slbc_pkg::REG_TYPE_IMPORTS:     type_imports     <= cfg_data;
        slbc_pkg::REG_TYPE_CHECKSUMS:   type_checksums   <= cfg_data;
        slbc_pkg::REG_TYPE_NO_BITS:     type_no_bits     <= cfg_data;
        slbc_pkg::REG_TYPE_EXPORTS:     type_exports     <= cfg_data;
        default: ;
      endcase
    end
  end

  // The table end is a registered copy computed from the config; config must only
  // change while idle (the block does not enforce this), so it is settled before a last word reaches the check.
  always_ff @(posedge clk) begin
    tbl_end <= ({16'd0, table_count} * {16'd0, table_entry_size}) + table_offset;
  end

  // ---------------------------------------------------------------------------
  // Stage A: classify on accept, hold in the input register
  // ---------------------------------------------------------------------------
  logic [AW-1:0] sec_size, sec_type, sec_flags, sec_offset;
  logic          in_skip;
  slbc_pkg::class_t in_cls;

  assign sec_size   = s_tdata[31:0];
  assign sec_type   = s_tdata[63:32];
  assign sec_flags  = s_tdata[95:64];
  assign sec_offset = s_tdata[127:96];

  // Drop empty sections and the skipped types.
  assign in_skip = (sec_size == '0) || (sec_type == type_file_info) ||
                   (sec_type == type_imports) || (sec_type == type_checksums) ||
                   (sec_type == type_no_bits);

  always_comb begin
    if (sec_flags[slbc_pkg::FLAG_EXEC_BIT] && (sec_type != type_exports)) begin
      in_cls = slbc_pkg::CLS_TEXT;
    end else if (sec_flags[slbc_pkg::FLAG_ALLOC_BIT]) begin
      in_cls = sec_flags[slbc_pkg::FLAG_WRITE_BIT] ? slbc_pkg::CLS_DATA
                                                   : slbc_pkg::CLS_READ;
    end else begin
      in_cls = slbc_pkg::CLS_TEMP;
    end
  end

  logic             b_valid;
  logic             b_join;
  logic             b_last;
  slbc_pkg::class_t b_cls;
  logic [AW-1:0]    b_off;
  logic [AW-1:0]    b_end;
  logic             b_go;     // stage B consumes its word this cycle
  logic             in_fire;

  // ---------------------------------------------------------------------------
  // Downstream handshake
  // ---------------------------------------------------------------------------
  logic out_free, c_valid, c_adv, c_free, c_load;

  assign out_free = !m_tvalid || m_tready;
  assign c_adv    = c_valid && out_free;
  assign c_free   = !c_valid || out_free;
  // Ordinary words always move; a last word needs the check register.
  assign b_go     = b_valid && (!b_last || c_free);
  assign c_load   = b_go && b_last;
  assign s_tready = !b_valid || b_go;
  assign in_fire  = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (in_fire) begin
      b_valid <= 1'b1;
    end else if (b_go) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      b_join <= !in_skip;
      b_last <= s_tlast;
      b_cls  <= in_cls;
      b_off  <= sec_offset;
      b_end  <= sec_offset + sec_size;   // wraps modulo 2^32
    end
  end

  // ---------------------------------------------------------------------------
  // Stage B: per-class running min start / max end
  // ---------------------------------------------------------------------------
  logic [NC-1:0][AW-1:0] class_min, class_max;
  logic [NC-1:0]         class_used;
  slbc_pkg::span_t       span_next;

  always_comb begin
    for (int k = 0; k < NC; k++) begin
      logic hit;
      hit = b_join && (b_cls == 2'(k));
      span_next.lo[k]   = (hit && (b_off < class_min[k])) ? b_off : class_min[k];
      span_next.hi[k]   = (hit && (b_end > class_max[k])) ? b_end : class_max[k];
      span_next.used[k] = class_used[k] || hit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || c_load) begin
      // A last word closes the image: start the next one from scratch.
      class_min  <= {NC{slbc_pkg::ALL_ONES}};
      class_max  <= '0;
      class_used <= '0;
    end else if (b_go) begin
      class_min  <= span_next.lo;
      class_max  <= span_next.hi;
      class_used <= span_next.used;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage C: final snapshot, defaults and checks into the result register
  // ---------------------------------------------------------------------------
  slbc_pkg::span_t c_span;
  slbc_pkg::fail_t c_code;
  slbc_pkg::fail_t out_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (c_load) begin
      c_valid <= 1'b1;
    end else if (c_adv) begin
      c_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (c_load) begin
      c_span <= span_next;
    end
  end

  slbc_check u_check (
    .span       (c_span),
    .tbl_offset (table_offset),
    .tbl_end    (tbl_end),
    .code       (c_code)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (c_adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (c_adv) begin
      out_code <= c_code;
    end
  end

  assign m_tdata = {3'b000, out_code, (out_code == slbc_pkg::FAIL_NONE)};

`ifndef ASSERT_OFF
  // A closed image leaves every class empty.
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    c_load |=> (class_used == '0))
    else $error("class state not cleared after last section");

  // Reported code never exceeds the last check.
  a_code_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[4:1] <= slbc_pkg::FAIL_TEMP_LO_HI))
    else $error("fail code out of range");

  // A result only enters the check register from a last word.
  a_check_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(c_valid) |-> $past(b_valid && b_last))
    else $error("check started without a last section");

  // The input side never takes a word while stage B is stuck.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (b_valid && !b_go) |-> !s_tready)
    else $error("input accepted while stage B held");
`endif

endmodule

[tb/tb_section_layout_bounds_check.sv]
// Testbench for the section layout bounds checker: streamed headers, predicted verdicts.
`timescale 1ns / 100ps

module tb_section_layout_bounds_check;

  // Flag masks built from the package bit positions.
  localparam logic [31:0] FL_WRITE = 32'd1 << slbc_pkg::FLAG_WRITE_BIT;
  localparam logic [31:0] FL_ALLOC = 32'd1 << slbc_pkg::FLAG_ALLOC_BIT;
  localparam logic [31:0] FL_EXEC  = 32'd1 << slbc_pkg::FLAG_EXEC_BIT;

  // One section header as it travels on the input stream.
  typedef struct {
    logic [31:0] sec_size;
    logic [31:0] sec_type;
    logic [31:0] sec_flags;
    logic [31:0] sec_offset;
    logic        last_section;
  } hdr_t;

  // One layout verdict as it comes back on the output stream.
  typedef struct {
    logic            layout_ok;
    slbc_pkg::fail_t fail_code;
  } verdict_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_wr_en = 1'b0;
  logic [2:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [127:0] s_tdata = '0;   // sec_size, sec_type, sec_flags, sec_offset
  logic         s_tlast = 1'b0; // last_section
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [7:0]   m_tdata;        // layout_ok, fail_code[3:0], zero fill

  section_layout_bounds_check uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow copy of the register file, kept in step with every write.
  logic [31:0] tbl_offset   = 32'd0;
  logic [15:0] tbl_count    = 16'd0;
  logic [15:0] tbl_entry    = 16'd40;
  logic [31:0] ty_file_info = 32'h8000_0004;
  logic [31:0] ty_imports   = 32'h8000_0002;
  logic [31:0] ty_checksums = 32'h8000_0003;
  logic [31:0] ty_no_bits   = 32'h8000_0000 >> 28; // 8
  logic [31:0] ty_exports   = 32'h8000_0001;

  // Per-class span tracking, indexed by class_t.
  logic [31:0] span_lo   [slbc_pkg::NUM_CLASSES];
  logic [31:0] span_hi   [slbc_pkg::NUM_CLASSES];
  logic        span_used [slbc_pkg::NUM_CLASSES];

  hdr_t     pending[$];       // headers waiting for the driver
  verdict_t verdicts_due[$];  // predicted verdicts, oldest first
  hdr_t     on_bus;           // header currently presented on s_tdata
  int       queued_items = 0; // headers queued that join a class
  int       fails = 0;
  int       cyc = 0;

  // Stretch of the run with no idling on either side.
  wire quiet = (cyc >= 300 && cyc < 550);

  always @(posedge clk) cyc <= cyc + 1;

  function automatic void clear_spans();
    for (int k = 0; k < slbc_pkg::NUM_CLASSES; k++) begin
      span_lo[k]   = slbc_pkg::ALL_ONES;
      span_hi[k]   = '0;
      span_used[k] = 1'b0;
    end
  endfunction

  // End of the header table, which is where an empty data class sits.
  function automatic logic [31:0] table_end();
    logic [31:0] prod;
    prod = {16'd0, tbl_count} * {16'd0, tbl_entry};
    return prod + tbl_offset;
  endfunction

  function automatic bit is_skipped(input hdr_t h);
    return h.sec_size == 0 || h.sec_type == ty_file_info || h.sec_type == ty_imports ||
           h.sec_type == ty_checksums || h.sec_type == ty_no_bits;
  endfunction

  // Fold one accepted header into the spans; on the last one, judge the
  // layout, queue the verdict and clear the spans.
  function automatic void absorb_header(input hdr_t h);
    slbc_pkg::class_t cls;
    logic [31:0]      sec_end;
    logic [31:0]      prev_end;
    logic [31:0]      lo [slbc_pkg::NUM_CLASSES];
    logic [31:0]      hi [slbc_pkg::NUM_CLASSES];
    verdict_t         v;
    if (!is_skipped(h)) begin
      sec_end = h.sec_offset + h.sec_size;  // wraps modulo 2^32
      if (h.sec_flags[slbc_pkg::FLAG_EXEC_BIT] && h.sec_type != ty_exports) begin
        cls = slbc_pkg::CLS_TEXT;
      end else if (h.sec_flags[slbc_pkg::FLAG_ALLOC_BIT]) begin
        cls = h.sec_flags[slbc_pkg::FLAG_WRITE_BIT] ? slbc_pkg::CLS_DATA
                                                    : slbc_pkg::CLS_READ;
      end else begin
        cls = slbc_pkg::CLS_TEMP;
      end
      if (h.sec_offset < span_lo[cls]) span_lo[cls] = h.sec_offset;
      if (sec_end > span_hi[cls]) span_hi[cls] = sec_end;
      span_used[cls] = 1'b1;
    end
    if (h.last_section) begin
      // Empty classes collapse onto the end of the previous one in the chain.
      prev_end = table_end();
      for (int k = 0; k < slbc_pkg::NUM_CLASSES; k++) begin
        lo[k] = span_used[k] ? span_lo[k] : prev_end;
        hi[k] = span_used[k] ? span_hi[k] : prev_end;
        prev_end = hi[k];
      end
      if (lo[slbc_pkg::CLS_DATA] < tbl_offset)
        v.fail_code = slbc_pkg::FAIL_DATA_BEFORE_TBL;
      else if (lo[slbc_pkg::CLS_DATA] > hi[slbc_pkg::CLS_DATA])
        v.fail_code = slbc_pkg::FAIL_DATA_LO_HI;
      else if (lo[slbc_pkg::CLS_DATA] > lo[slbc_pkg::CLS_READ])
        v.fail_code = slbc_pkg::FAIL_DATA_LO_READ;
      else if (hi[slbc_pkg::CLS_DATA] > lo[slbc_pkg::CLS_READ])
        v.fail_code = slbc_pkg::FAIL_DATA_HI_READ;
      else if (lo[slbc_pkg::CLS_READ] > hi[slbc_pkg::CLS_READ])
        v.fail_code = slbc_pkg::FAIL_READ_LO_HI;
      else if (lo[slbc_pkg::CLS_READ] > lo[slbc_pkg::CLS_TEXT])
        v.fail_code = slbc_pkg::FAIL_READ_LO_TEXT;
      else if (hi[slbc_pkg::CLS_READ] > lo[slbc_pkg::CLS_TEXT])
        v.fail_code = slbc_pkg::FAIL_READ_HI_TEXT;
      else if (lo[slbc_pkg::CLS_TEXT] > hi[slbc_pkg::CLS_TEXT])
        v.fail_code = slbc_pkg::FAIL_TEXT_LO_HI;
      else if (lo[slbc_pkg::CLS_TEXT] > lo[slbc_pkg::CLS_TEMP])
        v.fail_code = slbc_pkg::FAIL_TEXT_LO_TEMP;
      else if (hi[slbc_pkg::CLS_TEXT] > lo[slbc_pkg::CLS_TEMP])
        v.fail_code = slbc_pkg::FAIL_TEXT_HI_TEMP;
      else if (lo[slbc_pkg::CLS_TEMP] > hi[slbc_pkg::CLS_TEMP])
        v.fail_code = slbc_pkg::FAIL_TEMP_LO_HI;
      else
        v.fail_code = slbc_pkg::FAIL_NONE;
      v.layout_ok = (v.fail_code == slbc_pkg::FAIL_NONE);
      verdicts_due.push_back(v);
      clear_spans();
    end
  endfunction

  // Driver: present queued headers, idle at random, predict on each handshake.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) absorb_header(on_bus);
      if (!s_tvalid || s_tready) begin
        if (pending.size() != 0 && (quiet || $urandom_range(99) >= 25)) begin
          on_bus = pending.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {on_bus.sec_offset, on_bus.sec_flags, on_bus.sec_type, on_bus.sec_size};
          s_tlast  <= on_bus.last_section;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: stall at random, check each accepted verdict against the oldest prediction.
  always @(posedge clk) begin
    verdict_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (verdicts_due.size() == 0) begin
          $display("%0t: unexpected verdict word %h", $time, m_tdata);
          fails++;
        end else begin
          want = verdicts_due.pop_front();
          if (m_tdata[0] !== want.layout_ok || m_tdata[4:1] !== want.fail_code ||
              m_tdata[7:5] !== 3'b000) begin
            $display({"%0t: verdict mismatch: expected ok=%0b code=%0d, ",
                      "actual ok=%0b code=%0d pad=%b"},
                     $time, want.layout_ok, want.fail_code, m_tdata[0], m_tdata[4:1],
                     m_tdata[7:5]);
            fails++;
          end
        end
      end
      m_tready <= quiet || ($urandom_range(99) >= 25);
    end
  end

  task automatic enqueue(input hdr_t h);
    pending.push_back(h);
    if (!is_skipped(h)) queued_items++;
  endtask

  task automatic push_hdr(input logic [31:0] size, input logic [31:0] sec_type,
                          input logic [31:0] flags, input logic [31:0] offset,
                          input logic last);
    hdr_t h;
    h.sec_size = size;
    h.sec_type = sec_type;
    h.sec_flags = flags;
    h.sec_offset = offset;
    h.last_section = last;
    enqueue(h);
  endtask

  // Type code that is neither skipped nor the export type.
  function automatic logic [31:0] plain_type();
    logic [31:0] t;
    do begin
      t = ($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 15)) : 32'($urandom());
    end while (t == ty_file_info || t == ty_imports || t == ty_checksums ||
               t == ty_no_bits || t == ty_exports);
    return t;
  endfunction

  // Header with every field drawn wide, leaning on the corner values.
  function automatic hdr_t rand_header();
    hdr_t h;
    case ($urandom_range(0, 9))
      0:       h.sec_size = '0;
      1:       h.sec_size = slbc_pkg::ALL_ONES;
      2:       h.sec_size = 32'($urandom_range(1, 256));
      default: h.sec_size = $urandom();
    endcase
    case ($urandom_range(0, 7))
      0:       h.sec_type = ty_file_info;
      1:       h.sec_type = ty_imports;
      2:       h.sec_type = ty_checksums;
      3:       h.sec_type = ty_no_bits;
      4:       h.sec_type = ty_exports;
      5:       h.sec_type = 32'($urandom_range(0, 15));
      default: h.sec_type = $urandom();
    endcase
    h.sec_flags = $urandom();
    case ($urandom_range(0, 9))
      0:       h.sec_offset = '0;
      1:       h.sec_offset = slbc_pkg::ALL_ONES;
      default: h.sec_offset = $urandom();
    endcase
    h.last_section = 1'b0;
    return h;
  endfunction

  // Close a frame: shuffle it, mark the final header last, hand it to the driver.
  task automatic send_frame(input hdr_t frame[$]);
    hdr_t t;
    int   j;
    for (int i = frame.size() - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = frame[i];
      frame[i] = frame[j];
      frame[j] = t;
    end
    frame[frame.size() - 1].last_section = 1'b1;
    foreach (frame[i]) enqueue(frame[i]);
  endtask

  // Well-formed image: classes laid out in chain order past the table, with
  // occasional ignored headers and one broken section now and then.
  task automatic queue_layout_frame();
    hdr_t        frame[$];
    hdr_t        h;
    logic [31:0] cursor;
    int          j;
    cursor = table_end() + 32'($urandom_range(0, 64));
    for (int c = 0; c < slbc_pkg::NUM_CLASSES; c++) begin
      repeat ($urandom_range(0, 3)) begin
        h.sec_size = 32'($urandom_range(1, 1024));
        h.sec_offset = cursor;
        cursor = cursor + h.sec_size +
                 (($urandom_range(0, 3) == 0) ? 32'd0 : 32'($urandom_range(1, 64)));
        h.sec_type = plain_type();
        h.sec_flags = $urandom() & 32'hFFFF_FFF8;
        case (slbc_pkg::class_t'(c))
          slbc_pkg::CLS_DATA: h.sec_flags |= FL_ALLOC | FL_WRITE;
          slbc_pkg::CLS_READ: h.sec_flags |= FL_ALLOC;
          slbc_pkg::CLS_TEXT: h.sec_flags |= FL_EXEC | 32'($urandom_range(0, 3));
          default:            h.sec_flags |= 32'($urandom_range(0, 1));  // write bit random, no alloc
        endcase
        // Exported code lands in data or read, never in text.
        if (c < 2 && $urandom_range(0, 3) == 0) begin
          h.sec_type = ty_exports;
          h.sec_flags |= FL_EXEC;
        end
        h.last_section = 1'b0;
        frame.push_back(h);
      end
    end
    if (frame.size() == 0 || $urandom_range(0, 3) == 0) begin
      h = rand_header();
      if ($urandom_range(0, 1) == 0) h.sec_size = '0;
      else h.sec_type = ty_no_bits;
      frame.push_back(h);
    end
    if ($urandom_range(99) < 35) begin
      j = $urandom_range(0, frame.size() - 1);
      case ($urandom_range(0, 2))
        0:       frame[j].sec_offset = $urandom();
        1:       frame[j].sec_size = $urandom();
        default: frame[j].sec_offset = 32'($urandom_range(0, 64));
      endcase
    end
    send_frame(frame);
  endtask

  task automatic queue_noise_frame();
    hdr_t frame[$];
    repeat ($urandom_range(1, 6)) frame.push_back(rand_header());
    send_frame(frame);
  endtask

  // Wait until the driver is empty and every verdict is in, then let the
  // pipeline run dry so headers that gave no verdict have landed too.
  task automatic settle();
    int guard;
    guard = 0;
    @(negedge clk);
    while ((pending.size() != 0 || s_tvalid || verdicts_due.size() != 0) && guard < 50000) begin
      @(negedge clk);
      guard++;
    end
    if (verdicts_due.size() != 0) begin
      $display("%0t: %0d verdicts never arrived", $time, verdicts_due.size());
      fails++;
      verdicts_due.delete();
    end
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input slbc_pkg::reg_index_t idx, input logic [31:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      slbc_pkg::REG_TABLE_OFFSET:     tbl_offset = val;
      slbc_pkg::REG_TABLE_COUNT:      tbl_count = val[15:0];
      slbc_pkg::REG_TABLE_ENTRY_SIZE: tbl_entry = val[15:0];
      slbc_pkg::REG_TYPE_FILE_INFO:   ty_file_info = val;
      slbc_pkg::REG_TYPE_IMPORTS:     ty_imports = val;
      slbc_pkg::REG_TYPE_CHECKSUMS:   ty_checksums = val;
      slbc_pkg::REG_TYPE_NO_BITS:     ty_no_bits = val;
      default:                        ty_exports = val;
    endcase
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic program_regs(input logic [31:0] off, cnt, ent, fi, im, ck, nb, ex);
    write_reg(slbc_pkg::REG_TABLE_OFFSET, off);
    write_reg(slbc_pkg::REG_TABLE_COUNT, cnt);
    write_reg(slbc_pkg::REG_TABLE_ENTRY_SIZE, ent);
    write_reg(slbc_pkg::REG_TYPE_FILE_INFO, fi);
    write_reg(slbc_pkg::REG_TYPE_IMPORTS, im);
    write_reg(slbc_pkg::REG_TYPE_CHECKSUMS, ck);
    write_reg(slbc_pkg::REG_TYPE_NO_BITS, nb);
    write_reg(slbc_pkg::REG_TYPE_EXPORTS, ex);
  endtask

  // Random images, mostly well formed; optionally hold the sender halfway
  // until every verdict so far has come back.
  task automatic run_images(input int target, input bit hold_midway);
    int start;
    bit held;
    start = queued_items;
    held = 1'b0;
    while (queued_items - start < target) begin
      if ($urandom_range(99) < 80) queue_layout_frame();
      else queue_noise_frame();
      if (hold_midway && !held && queued_items - start >= target / 2) begin
        settle();
        held = 1'b1;
      end
    end
  endtask

  initial begin
    clear_spans();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed images under the reset register values.
    // All classes empty: everything collapses onto the table end.
    push_hdr(32'd0, 32'd1, FL_EXEC, 32'h40, 1'b1);
    // Every skipped type, then a zero-size last header.
    push_hdr(32'h10, ty_file_info, FL_ALLOC | FL_WRITE, 32'h10, 1'b0);
    push_hdr(32'h10, ty_imports, FL_ALLOC, 32'h20, 1'b0);
    push_hdr(32'h10, ty_checksums, FL_EXEC, 32'h30, 1'b0);
    push_hdr(32'h10, ty_no_bits, FL_WRITE, 32'h40, 1'b0);
    push_hdr(32'd0, 32'd2, FL_ALLOC, 32'h50, 1'b1);
    // Clean image with one section per class.
    push_hdr(32'h100, 32'd1, FL_ALLOC | FL_WRITE, 32'h100, 1'b0);
    push_hdr(32'h80, 32'd1, FL_ALLOC, 32'h200, 1'b0);
    push_hdr(32'h100, 32'd3, FL_EXEC | FL_ALLOC | FL_WRITE, 32'h300, 1'b0);
    push_hdr(32'h10, 32'd4, FL_WRITE, 32'h400, 1'b1);
    // Executable export section goes to read, not text.
    push_hdr(32'h10, ty_exports, FL_EXEC | FL_ALLOC, 32'h1000, 1'b1);
    // Section at the top offset: end wraps to zero, temp span inverted.
    push_hdr(32'd1, 32'd2, 32'd0, slbc_pkg::ALL_ONES, 1'b1);
    // Data end wraps below its start.
    push_hdr(32'h200, 32'd2, FL_ALLOC | FL_WRITE, 32'hFFFF_FF00, 1'b1);
    // Extreme header: full size, all flags set, top type code.
    push_hdr(slbc_pkg::ALL_ONES, slbc_pkg::ALL_ONES, slbc_pkg::ALL_ONES, 32'd0, 1'b1);
    // Data overlapping read, then temp placed ahead of text.
    push_hdr(32'h100, 32'd1, FL_ALLOC | FL_WRITE, 32'h100, 1'b0);
    push_hdr(32'h10, 32'd1, FL_ALLOC, 32'h180, 1'b1);
    push_hdr(32'h100, 32'd1, FL_EXEC, 32'h1000, 1'b0);
    push_hdr(32'h10, 32'd1, 32'd0, 32'h800, 1'b1);
    run_images(90, 1'b0);
    settle();

    // Typical table placement; upper halves of the 16-bit writes are dropped.
    program_regs(32'h34, 32'hABCD_000C, 32'h5A5A_0028, 32'h8000_0004, 32'h8000_0002,
                 32'h8000_0003, 32'd8, 32'h8000_0001);
    run_images(100, 1'b1);
    settle();

    // Everything at zero.
    program_regs(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    run_images(100, 1'b0);
    settle();

    // Everything at the top; table end wraps around.
    program_regs(slbc_pkg::ALL_ONES, slbc_pkg::ALL_ONES, slbc_pkg::ALL_ONES,
                 slbc_pkg::ALL_ONES, slbc_pkg::ALL_ONES, slbc_pkg::ALL_ONES,
                 slbc_pkg::ALL_ONES, slbc_pkg::ALL_ONES);
    run_images(100, 1'b0);
    settle();

    // Random register file.
    program_regs($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                 $urandom(), $urandom());
    run_images(100, 1'b0);
    settle();

    // Table high in the file, many small entries.
    program_regs(32'h8000_0000, 32'hFFFF, 32'd1, 32'h7000_0000, 32'h7000_0001,
                 32'h7000_0002, 32'h7000_0003, 32'h7000_0004);
    run_images(100, 1'b0);
    settle();

    if (fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #400000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

[sim.f]
hdl/slbc_pkg.sv
hdl/slbc_check.sv
hdl/section_layout_bounds_check.sv
tb/tb_section_layout_bounds_check.sv
